### rtl/rwlt_pkg.sv
// Shared types and codes for the reader/writer lock table.
package rwlt_pkg;

    localparam logic [2:0] MODE_READ    = 3'd0;
    localparam logic [2:0] MODE_WRITE   = 3'd1;
    localparam logic [2:0] MODE_REL_ONE = 3'd2;
    localparam logic [2:0] MODE_REL_ALL = 3'd3;
    localparam logic [2:0] MODE_QUERY   = 3'd4;

    localparam logic [3:0] VARS_RESET  = 4'd8;
    localparam int         MAX_RESULTS = 8;
    localparam int         KW          = 4;

    typedef enum logic [3:0] {
        EV_READ_GRANTED  = 4'd0,
        EV_WRITE_GRANTED = 4'd1,
        EV_UPGRADE       = 4'd2,
        EV_READ_WAIT     = 4'd3,
        EV_WRITE_WAIT    = 4'd4,
        EV_UNLOCKED      = 4'd5,
        EV_NO_LOCK       = 4'd6,
        EV_CULPRITS      = 4'd7,
        EV_REJECTED      = 4'd8
    } t_event;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_REJECT,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_EX,
        S_SCAN_END
    } t_state;

    typedef struct packed {
        logic [2:0] mode;
        logic [3:0] tx_id;
        logic [2:0] var_index;
    } t_req;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [3:0]  result_tx;
        logic [2:0]  result_var;
        logic [15:0] woken_set;
        logic        woken_as_writer;
        logic [15:0] waiting_set;
        logic        last;
    } t_res;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic rd_scan;
        logic scan_clr;
        logic exec_single;
        logic scan_step;
        logic emit_reject;
        logic emit_end;
    } t_ctl_cmd;

    typedef struct packed {
        logic bad;
        logic is_query;
        logic is_rel_all;
        logic waiting;
        logic var_bad;
        logic scan_done;
        logic scan_block;
        logic out_free;
    } t_ctl_sts;

endpackage

### rtl/rwlt_ctrl.sv
// Request sequencer for the lock table.
module rwlt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rwlt_pkg::t_ctl_sts i_sts,
    output rwlt_pkg::t_ctl_cmd o_cmd
);
    import rwlt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.bad) begin
                    n_state = S_REJECT;
                end else if (i_sts.is_query) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN_RD;
                end else if (i_sts.waiting) begin
                    n_state = S_REJECT;
                end else if (i_sts.is_rel_all) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN_RD;
                end else if (i_sts.var_bad) begin
                    n_state = S_REJECT;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_REJECT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_reject = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec_single = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            S_SCAN_RD: begin
                if (i_sts.scan_done) begin
                    n_state = S_SCAN_END;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_scan = 1'b1;
                    n_state       = S_SCAN_EX;
                end
            end
            S_SCAN_EX: begin
                if (!i_sts.scan_block) begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = S_SCAN_RD;
                end
            end
            S_SCAN_END: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### rtl/rwlt_datapath.sv
// Lock table storage, lock update logic and result registers.
module rwlt_datapath #(
    parameter int NUM_VARS = 8,
    parameter int NUM_TX   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [3:0]         i_cfg_data,
    input  rwlt_pkg::t_req     i_in_req,
    input  rwlt_pkg::t_ctl_cmd i_cmd,
    output rwlt_pkg::t_ctl_sts o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rwlt_pkg::t_res     o_out_res
);
    import rwlt_pkg::*;

    localparam int TXW = $clog2(NUM_TX);
    localparam int VIW = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int VCW = $clog2(NUM_VARS + 1);
    localparam int EW  = 3 * NUM_TX + 1 + TXW;

    logic [EW-1:0]       mem [NUM_VARS];
    logic [NUM_VARS-1:0] r_ent_vld;
    logic [EW-1:0]       r_rd_data;
    logic                r_rd_vld;

    logic [3:0]        r_vars;
    t_req              r_req;
    logic [NUM_TX-1:0] r_wait_any;
    logic [VCW-1:0]    r_cnt;
    logic [NUM_TX-1:0] r_acc;
    logic [KW-1:0]     r_k;
    t_res              r_held;
    logic              r_held_vld;
    t_res              r_out;
    logic              r_out_valid;

    logic [7:0]        nv8;
    logic [VIW+2:0]    var_ext;
    logic [VIW-1:0]    var_addr;
    logic [VIW-1:0]    cnt_addr;
    logic [VIW-1:0]    raddr;
    logic [VIW-1:0]    waddr;
    logic [VCW+2:0]    cnt_ext;
    logic [NUM_TX-1:0] tx_bit;
    logic [EW-1:0]     ent;
    logic [NUM_TX-1:0] rs, wr, ww;
    logic              wv;
    logic [TXW-1:0]    wid;
    logic [NUM_TX-1:0] n_rs, n_wr, n_ww;
    logic              n_wv;
    logic [TXW-1:0]    n_wid;
    logic [NUM_TX-1:0] low_bit;
    logic [TXW-1:0]    low_idx;
    logic [NUM_TX-1:0] woken;
    logic              as_wr;
    logic              hit;
    logic              add_wait;
    logic              is_wr;
    logic              has_rd;
    t_event            ev;
    logic [NUM_TX+15:0] woken_ext;
    logic [NUM_TX+15:0] acc_ext;
    logic              out_free;
    logic              k_lt;
    logic              push;
    logic              we;
    logic              load;
    t_res              n_out;

    assign nv8      = (8'(r_vars) > 8'(NUM_VARS)) ? 8'(NUM_VARS) : 8'(r_vars);
    assign var_ext  = {{VIW{1'b0}}, r_req.var_index};
    assign var_addr = var_ext[VIW-1:0];
    assign cnt_addr = r_cnt[VIW-1:0];
    assign cnt_ext  = {3'b000, r_cnt};
    assign raddr    = i_cmd.rd_scan ? cnt_addr : var_addr;
    assign waddr    = i_cmd.exec_single ? var_addr : cnt_addr;

    always_comb begin
        for (int i = 0; i < NUM_TX; i++) begin
            tx_bit[i] = (8'(r_req.tx_id) == 8'(i));
        end
    end

    assign ent = r_rd_vld ? r_rd_data : '0;
    assign {rs, wv, wid, wr, ww} = ent;
    assign is_wr  = wv && (8'(wid) == 8'(r_req.tx_id));
    assign has_rd = |(rs & tx_bit);

    always_comb begin
        n_rs     = rs;
        n_wv     = wv;
        n_wid    = wid;
        n_wr     = wr;
        n_ww     = ww;
        ev       = EV_REJECTED;
        woken    = '0;
        as_wr    = 1'b0;
        hit      = 1'b0;
        add_wait = 1'b0;
        low_bit  = '0;
        low_idx  = '0;
        case (r_req.mode)
            MODE_READ: begin
                if (is_wr || has_rd) begin
                    ev = EV_READ_GRANTED;
                end else if (wv || (|ww)) begin
                    n_wr     = wr | tx_bit;
                    add_wait = 1'b1;
                    ev       = EV_READ_WAIT;
                end else begin
                    n_rs = rs | tx_bit;
                    ev   = EV_READ_GRANTED;
                end
            end
            MODE_WRITE: begin
                if (is_wr) begin
                    ev = EV_WRITE_GRANTED;
                end else begin
                    n_rs = rs & ~tx_bit;
                    if (wv || (|n_rs)) begin
                        n_ww     = ww | tx_bit;
                        add_wait = 1'b1;
                        ev       = EV_WRITE_WAIT;
                    end else begin
                        n_wv  = 1'b1;
                        n_wid = TXW'(r_req.tx_id);
                        ev    = has_rd ? EV_UPGRADE : EV_WRITE_GRANTED;
                    end
                end
            end
            MODE_REL_ONE, MODE_REL_ALL: begin
                ev = EV_NO_LOCK;
                if (has_rd) begin
                    n_rs = rs & ~tx_bit;
                    hit  = 1'b1;
                end else if (is_wr) begin
                    n_wv  = 1'b0;
                    n_wid = '0;
                    hit   = 1'b1;
                end
                if (hit) begin
                    ev = EV_UNLOCKED;
                    if (!n_wv && (n_rs == '0) && (|n_ww)) begin
                        low_bit = n_ww & (~n_ww + NUM_TX'(1));
                        for (int i = 0; i < NUM_TX; i++) begin
                            if (low_bit[i]) begin
                                low_idx = low_idx | TXW'(i);
                            end
                        end
                        n_ww  = n_ww & ~low_bit;
                        n_wv  = 1'b1;
                        n_wid = low_idx;
                        as_wr = 1'b1;
                        woken = low_bit;
                    end else if (!n_wv && (n_ww == '0) && (|n_wr)) begin
                        n_rs  = n_rs | n_wr;
                        woken = n_wr;
                        n_wr  = '0;
                    end
                end
            end
            default: begin
                ev = EV_REJECTED;
            end
        endcase
    end

    assign woken_ext = {16'h0000, woken};
    assign acc_ext   = {16'h0000, r_acc};
    assign out_free  = !r_out_valid || i_out_ready;
    assign k_lt      = r_k < KW'(MAX_RESULTS);
    assign push      = i_cmd.scan_step && (r_req.mode == MODE_REL_ALL) && hit && k_lt;
    assign we        = i_cmd.exec_single || (i_cmd.scan_step && (r_req.mode == MODE_REL_ALL));

    always_comb begin
        load  = 1'b0;
        n_out = r_out;
        if (i_cmd.emit_reject) begin
            load  = 1'b1;
            n_out = '{EV_REJECTED, r_req.tx_id, r_req.var_index, 16'h0000, 1'b0,
                      16'h0000, 1'b1};
        end else if (i_cmd.exec_single) begin
            load  = 1'b1;
            n_out = '{ev, r_req.tx_id, r_req.var_index, woken_ext[15:0], as_wr,
                      16'h0000, 1'b1};
        end else if (i_cmd.emit_end) begin
            load = 1'b1;
            if (r_req.mode == MODE_QUERY) begin
                n_out = '{EV_CULPRITS, r_req.tx_id, 3'd0, 16'h0000, 1'b0,
                          acc_ext[15:0], 1'b1};
            end else if (r_held_vld) begin
                n_out      = r_held;
                n_out.last = 1'b1;
            end else begin
                n_out = '{EV_NO_LOCK, r_req.tx_id, 3'd0, 16'h0000, 1'b0,
                          16'h0000, 1'b1};
            end
        end else if (push && r_held_vld) begin
            load  = 1'b1;
            n_out = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= {n_rs, n_wv, n_wid, n_wr, n_ww};
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld   <= '0;
            r_rd_vld    <= 1'b0;
            r_vars      <= VARS_RESET;
            r_wait_any  <= '0;
            r_held_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (we) begin
                r_ent_vld[waddr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_vld <= r_ent_vld[raddr];
            end
            if (i_cfg_we) begin
                r_vars <= i_cfg_data;
            end
            if (we) begin
                r_wait_any <= (r_wait_any & ~woken) | (add_wait ? tx_bit : '0);
            end
            if (i_cmd.scan_clr) begin
                r_held_vld <= 1'b0;
            end else if (push) begin
                r_held_vld <= 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in_req;
        end
        if (i_cmd.scan_clr) begin
            r_cnt <= '0;
            r_acc <= '0;
            r_k   <= '0;
        end else if (i_cmd.scan_step) begin
            r_cnt <= r_cnt + VCW'(1);
            if (r_req.mode == MODE_QUERY) begin
                r_acc <= r_acc | wr | ww;
            end
            if (push) begin
                r_k    <= r_k + KW'(1);
                r_held <= '{EV_UNLOCKED, r_req.tx_id, cnt_ext[2:0], woken_ext[15:0],
                            as_wr, 16'h0000, 1'b0};
            end
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_sts.bad        = (r_req.mode > MODE_QUERY) || (8'(r_req.tx_id) >= 8'(NUM_TX));
    assign o_sts.is_query   = (r_req.mode == MODE_QUERY);
    assign o_sts.is_rel_all = (r_req.mode == MODE_REL_ALL);
    assign o_sts.waiting    = |(r_wait_any & tx_bit);
    assign o_sts.var_bad    = 8'(r_req.var_index) >= nv8;
    assign o_sts.scan_done  = (8'(r_cnt) == nv8);
    assign o_sts.scan_block = (r_req.mode == MODE_REL_ALL) && hit && k_lt && r_held_vld
                              && !out_free;
    assign o_sts.out_free   = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

endmodule

### rtl/reader_writer_lock_table_unit.sv
// Top level of the reader/writer lock table.
// One request is handled at a time. Read, write and release-one requests
// pass through a check state and an execute state; rejected requests pass
// through the check state and a reject state. Release-all and the culprit
// query walk the variables in use through the table memory, with a read
// state and an update state per variable; the result side can stall them.
// Release-all gives one unlocked result per released variable (at most
// eight), the final one marked last. The table needs no clearing after reset.
module reader_writer_lock_table_unit #(
    parameter int NUM_VARS = 8,
    parameter int NUM_TX   = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [3:0]     i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  rwlt_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output rwlt_pkg::t_res o_out_res
);
    import rwlt_pkg::*;

    t_ctl_cmd w_cmd;
    t_ctl_sts w_sts;

    rwlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rwlt_datapath #(
        .NUM_VARS (NUM_VARS),
        .NUM_TX   (NUM_TX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_req    (i_in_req),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_res   (o_out_res)
    );

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.exec_single, w_cmd.scan_step, w_cmd.emit_reject, w_cmd.emit_end}))
        else $error("more than one table update or emit command at once");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.exec_single || w_cmd.emit_reject || w_cmd.emit_end) |-> w_sts.out_free)
        else $error("result emitted while output register is occupied");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.rd_en && w_cmd.rd_scan) |-> !w_sts.scan_done)
        else $error("scan read past the last variable in use");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("new request accepted before the current one finished");

endmodule
